FILE: hw/rtl/rid_pkg.sv
// rid_pkg: shared types, constants and the encoding table of the rv32imafd decoder
// used by rid_match, rid_extract and riscv_instruction_decoder; no dependencies
package rid_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned KIND_W      = 7;
   localparam int unsigned REG_W       = 5;
   localparam int unsigned NUM_ENTRIES = 110;
   localparam logic [15:0] DC          = 16'hFFFF;

   localparam logic [KIND_W-1:0] KIND_LUI   = KIND_W'(35);
   localparam logic [KIND_W-1:0] KIND_AUIPC = KIND_W'(36);

   typedef enum logic [2:0] {
      FMT_R,
      FMT_R4,
      FMT_I,
      FMT_S,
      FMT_B,
      FMT_U,
      FMT_J
   } fmt_type;

   typedef struct packed {
      logic [6:0]  opc;
      logic        f2_care;
      logic [1:0]  f2;
      logic        f3_care;
      logic [2:0]  f3;
      logic        f5a_care;
      logic [4:0]  f5a;
      logic        f5f_care;
      logic [4:0]  f5f;
      logic        f7_care;
      logic [6:0]  f7;
      logic        f12_care;
      logic [11:0] f12;
      fmt_type     fmt;
   } pattern_type;

   typedef struct packed {
      logic              hit;
      logic [KIND_W-1:0] kind;
      fmt_type           fmt;
   } match_type;

   function automatic pattern_type pat(
      input logic [15:0] opc, input logic [15:0] f2, input logic [15:0] f3,
      input logic [15:0] f5a, input logic [15:0] f5f, input logic [15:0] f7,
      input logic [15:0] f12, input fmt_type fmt);
      pattern_type p;
      p.opc      = opc[6:0];
      p.f2_care  = (f2 != DC);
      p.f2       = f2[1:0];
      p.f3_care  = (f3 != DC);
      p.f3       = f3[2:0];
      p.f5a_care = (f5a != DC);
      p.f5a      = f5a[4:0];
      p.f5f_care = (f5f != DC);
      p.f5f      = f5f[4:0];
      p.f7_care  = (f7 != DC);
      p.f7       = f7[6:0];
      p.f12_care = (f12 != DC);
      p.f12      = f12[11:0];
      p.fmt      = fmt;
      return p;
   endfunction

   localparam pattern_type PATTERNS [NUM_ENTRIES] = '{
      // rv32i
      pat(16'h33,DC,16'h0,DC,DC,16'h00,DC,FMT_R), pat(16'h33,DC,16'h0,DC,DC,16'h20,DC,FMT_R),
      pat(16'h33,DC,16'h4,DC,DC,16'h00,DC,FMT_R), pat(16'h33,DC,16'h6,DC,DC,16'h00,DC,FMT_R),
      pat(16'h33,DC,16'h7,DC,DC,16'h00,DC,FMT_R), pat(16'h33,DC,16'h1,DC,DC,16'h00,DC,FMT_R),
      pat(16'h33,DC,16'h5,DC,DC,16'h00,DC,FMT_R), pat(16'h33,DC,16'h5,DC,DC,16'h20,DC,FMT_R),
      pat(16'h33,DC,16'h2,DC,DC,16'h00,DC,FMT_R), pat(16'h33,DC,16'h3,DC,DC,16'h00,DC,FMT_R),
      pat(16'h13,DC,16'h0,DC,DC,DC,DC,FMT_I),     pat(16'h13,DC,16'h4,DC,DC,DC,DC,FMT_I),
      pat(16'h13,DC,16'h6,DC,DC,DC,DC,FMT_I),     pat(16'h13,DC,16'h7,DC,DC,DC,DC,FMT_I),
      pat(16'h13,DC,16'h1,DC,DC,16'h00,DC,FMT_I), pat(16'h13,DC,16'h5,DC,DC,16'h00,DC,FMT_I),
      pat(16'h13,DC,16'h5,DC,DC,16'h20,DC,FMT_I), pat(16'h13,DC,16'h2,DC,DC,DC,DC,FMT_I),
      pat(16'h13,DC,16'h3,DC,DC,DC,DC,FMT_I),
      pat(16'h03,DC,16'h0,DC,DC,DC,DC,FMT_I),     pat(16'h03,DC,16'h1,DC,DC,DC,DC,FMT_I),
      pat(16'h03,DC,16'h2,DC,DC,DC,DC,FMT_I),     pat(16'h03,DC,16'h4,DC,DC,DC,DC,FMT_I),
      pat(16'h03,DC,16'h5,DC,DC,DC,DC,FMT_I),
      pat(16'h23,DC,16'h0,DC,DC,DC,DC,FMT_S),     pat(16'h23,DC,16'h1,DC,DC,DC,DC,FMT_S),
      pat(16'h23,DC,16'h2,DC,DC,DC,DC,FMT_S),
      pat(16'h63,DC,16'h0,DC,DC,DC,DC,FMT_B),     pat(16'h63,DC,16'h1,DC,DC,DC,DC,FMT_B),
      pat(16'h63,DC,16'h4,DC,DC,DC,DC,FMT_B),     pat(16'h63,DC,16'h5,DC,DC,DC,DC,FMT_B),
      pat(16'h63,DC,16'h6,DC,DC,DC,DC,FMT_B),     pat(16'h63,DC,16'h7,DC,DC,DC,DC,FMT_B),
      pat(16'h6f,DC,DC,DC,DC,DC,DC,FMT_J),        pat(16'h67,DC,16'h0,DC,DC,DC,DC,FMT_I),
      pat(16'h37,DC,DC,DC,DC,DC,DC,FMT_U),        pat(16'h17,DC,DC,DC,DC,DC,DC,FMT_U),
      pat(16'h73,DC,16'h0,DC,DC,DC,16'h0,FMT_I),  pat(16'h73,DC,16'h0,DC,DC,DC,16'h1,FMT_I),
      // rv32m
      pat(16'h33,DC,16'h0,DC,DC,16'h01,DC,FMT_R), pat(16'h33,DC,16'h1,DC,DC,16'h01,DC,FMT_R),
      pat(16'h33,DC,16'h2,DC,DC,16'h01,DC,FMT_R), pat(16'h33,DC,16'h3,DC,DC,16'h01,DC,FMT_R),
      pat(16'h33,DC,16'h4,DC,DC,16'h01,DC,FMT_R), pat(16'h33,DC,16'h5,DC,DC,16'h01,DC,FMT_R),
      pat(16'h33,DC,16'h6,DC,DC,16'h01,DC,FMT_R), pat(16'h33,DC,16'h7,DC,DC,16'h01,DC,FMT_R),
      // rv32a
      pat(16'h2f,DC,16'h2,16'h02,DC,DC,DC,FMT_R), pat(16'h2f,DC,16'h2,16'h03,DC,DC,DC,FMT_R),
      pat(16'h2f,DC,16'h2,16'h01,DC,DC,DC,FMT_R), pat(16'h2f,DC,16'h2,16'h00,DC,DC,DC,FMT_R),
      pat(16'h2f,DC,16'h2,16'h0c,DC,DC,DC,FMT_R), pat(16'h2f,DC,16'h2,16'h08,DC,DC,DC,FMT_R),
      pat(16'h2f,DC,16'h2,16'h04,DC,DC,DC,FMT_R), pat(16'h2f,DC,16'h2,16'h14,DC,DC,DC,FMT_R),
      pat(16'h2f,DC,16'h2,16'h10,DC,DC,DC,FMT_R), pat(16'h2f,DC,16'h2,16'h1c,DC,DC,DC,FMT_R),
      pat(16'h2f,DC,16'h2,16'h18,DC,DC,DC,FMT_R),
      // rv32f
      pat(16'h07,DC,16'h2,DC,DC,DC,DC,FMT_I),     pat(16'h27,DC,16'h2,DC,DC,DC,DC,FMT_S),
      pat(16'h43,16'h0,DC,DC,DC,DC,DC,FMT_R4),    pat(16'h47,16'h0,DC,DC,DC,DC,DC,FMT_R4),
      pat(16'h4b,16'h0,DC,DC,DC,DC,DC,FMT_R4),    pat(16'h4f,16'h0,DC,DC,DC,DC,DC,FMT_R4),
      pat(16'h53,DC,DC,DC,DC,16'h00,DC,FMT_R),    pat(16'h53,DC,DC,DC,DC,16'h04,DC,FMT_R),
      pat(16'h53,DC,DC,DC,DC,16'h08,DC,FMT_R),    pat(16'h53,DC,DC,DC,DC,16'h0c,DC,FMT_R),
      pat(16'h53,DC,DC,DC,16'h00,16'h2c,DC,FMT_R),
      pat(16'h53,DC,16'h0,DC,DC,16'h10,DC,FMT_R), pat(16'h53,DC,16'h1,DC,DC,16'h10,DC,FMT_R),
      pat(16'h53,DC,16'h2,DC,DC,16'h10,DC,FMT_R),
      pat(16'h53,DC,16'h0,DC,DC,16'h14,DC,FMT_R), pat(16'h53,DC,16'h1,DC,DC,16'h14,DC,FMT_R),
      pat(16'h53,DC,DC,DC,16'h00,16'h60,DC,FMT_R), pat(16'h53,DC,DC,DC,16'h01,16'h60,DC,FMT_R),
      pat(16'h53,DC,16'h0,DC,16'h00,16'h70,DC,FMT_R),
      pat(16'h53,DC,16'h2,DC,DC,16'h50,DC,FMT_R), pat(16'h53,DC,16'h1,DC,DC,16'h50,DC,FMT_R),
      pat(16'h53,DC,16'h0,DC,DC,16'h50,DC,FMT_R),
      pat(16'h53,DC,16'h1,DC,16'h00,16'h70,DC,FMT_R),
      pat(16'h53,DC,DC,DC,16'h00,16'h68,DC,FMT_R), pat(16'h53,DC,DC,DC,16'h01,16'h68,DC,FMT_R),
      pat(16'h53,DC,16'h0,DC,16'h00,16'h78,DC,FMT_R),
      // rv32d
      pat(16'h07,DC,16'h3,DC,DC,DC,DC,FMT_I),     pat(16'h27,DC,16'h3,DC,DC,DC,DC,FMT_S),
      pat(16'h43,16'h1,DC,DC,DC,DC,DC,FMT_R4),    pat(16'h47,16'h1,DC,DC,DC,DC,DC,FMT_R4),
      pat(16'h4b,16'h1,DC,DC,DC,DC,DC,FMT_R4),    pat(16'h4f,16'h1,DC,DC,DC,DC,DC,FMT_R4),
      pat(16'h53,DC,DC,DC,DC,16'h01,DC,FMT_R),    pat(16'h53,DC,DC,DC,DC,16'h05,DC,FMT_R),
      pat(16'h53,DC,DC,DC,DC,16'h09,DC,FMT_R),    pat(16'h53,DC,DC,DC,DC,16'h0d,DC,FMT_R),
      pat(16'h53,DC,DC,DC,16'h00,16'h2d,DC,FMT_R),
      pat(16'h53,DC,16'h0,DC,DC,16'h11,DC,FMT_R), pat(16'h53,DC,16'h1,DC,DC,16'h11,DC,FMT_R),
      pat(16'h53,DC,16'h2,DC,DC,16'h11,DC,FMT_R),
      pat(16'h53,DC,16'h0,DC,DC,16'h15,DC,FMT_R), pat(16'h53,DC,16'h1,DC,DC,16'h15,DC,FMT_R),
      pat(16'h53,DC,DC,DC,16'h01,16'h20,DC,FMT_R), pat(16'h53,DC,DC,DC,16'h00,16'h21,DC,FMT_R),
      pat(16'h53,DC,16'h2,DC,DC,16'h51,DC,FMT_R), pat(16'h53,DC,16'h1,DC,DC,16'h51,DC,FMT_R),
      pat(16'h53,DC,16'h0,DC,DC,16'h51,DC,FMT_R),
      pat(16'h53,DC,16'h1,DC,16'h00,16'h71,DC,FMT_R),
      pat(16'h53,DC,DC,DC,16'h00,16'h61,DC,FMT_R), pat(16'h53,DC,DC,DC,16'h01,16'h61,DC,FMT_R),
      pat(16'h53,DC,DC,DC,16'h00,16'h69,DC,FMT_R), pat(16'h53,DC,16'h0,DC,16'h01,16'h69,DC,FMT_R)
   };

endpackage

FILE: hw/rtl/rid_match.sv
// rid_match: compares one instruction word against every table entry in parallel
// and picks the first hit; depends on rid_pkg
module rid_match (
   input  logic [rid_pkg::WORD_W-1:0] word,
   output rid_pkg::match_type         match
);

   logic [rid_pkg::NUM_ENTRIES-1:0] hit_vec;
   logic [6:0]  opc;
   logic [1:0]  f2;
   logic [2:0]  f3;
   logic [4:0]  f5a;
   logic [4:0]  f5f;
   logic [6:0]  f7;
   logic [11:0] f12;

   assign opc = word[6:0];
   assign f2  = word[26:25];
   assign f3  = word[14:12];
   assign f5a = word[31:27];
   assign f5f = word[24:20];
   assign f7  = word[31:25];
   assign f12 = word[31:20];

   always_comb begin
      for (int k = 0; k < rid_pkg::NUM_ENTRIES; k++) begin
         hit_vec[k] = (rid_pkg::PATTERNS[k].opc == opc)
            && (!rid_pkg::PATTERNS[k].f2_care  || rid_pkg::PATTERNS[k].f2  == f2)
            && (!rid_pkg::PATTERNS[k].f3_care  || rid_pkg::PATTERNS[k].f3  == f3)
            && (!rid_pkg::PATTERNS[k].f5a_care || rid_pkg::PATTERNS[k].f5a == f5a)
            && (!rid_pkg::PATTERNS[k].f5f_care || rid_pkg::PATTERNS[k].f5f == f5f)
            && (!rid_pkg::PATTERNS[k].f7_care  || rid_pkg::PATTERNS[k].f7  == f7)
            && (!rid_pkg::PATTERNS[k].f12_care || rid_pkg::PATTERNS[k].f12 == f12);
      end
   end

   // lowest index wins
   always_comb begin
      match.hit  = |hit_vec;
      match.kind = '0;
      match.fmt  = rid_pkg::FMT_R;
      for (int k = rid_pkg::NUM_ENTRIES - 1; k >= 0; k--) begin
         if (hit_vec[k]) begin
            match.kind = rid_pkg::KIND_W'(k);
            match.fmt  = rid_pkg::PATTERNS[k].fmt;
         end
      end
   end

endmodule

FILE: hw/rtl/rid_extract.sv
// rid_extract: pulls register indices and the sign-extended immediate out of the
// word for the matched format; depends on rid_pkg
module rid_extract (
   input  logic [rid_pkg::WORD_W-1:0] word,
   input  rid_pkg::match_type         match,
   output logic [rid_pkg::KIND_W-1:0] kind,
   output logic [rid_pkg::REG_W-1:0]  dest_reg,
   output logic [rid_pkg::REG_W-1:0]  src1_reg,
   output logic [rid_pkg::REG_W-1:0]  src2_reg,
   output logic [rid_pkg::REG_W-1:0]  src3_reg,
   output logic [rid_pkg::WORD_W-1:0] immediate,
   output logic                       illegal
);

   always_comb begin
      kind      = '0;
      dest_reg  = '0;
      src1_reg  = '0;
      src2_reg  = '0;
      src3_reg  = '0;
      immediate = '0;
      illegal   = !match.hit;
      if (match.hit) begin
         kind = match.kind;
         unique case (match.fmt)
            rid_pkg::FMT_R4: begin
               dest_reg = word[11:7];
               src1_reg = word[19:15];
               src2_reg = word[24:20];
               src3_reg = word[31:27];
            end
            rid_pkg::FMT_R: begin
               dest_reg = word[11:7];
               src1_reg = word[19:15];
               src2_reg = word[24:20];
            end
            rid_pkg::FMT_I: begin
               dest_reg  = word[11:7];
               src1_reg  = word[19:15];
               immediate = {{20{word[31]}}, word[31:20]};
            end
            rid_pkg::FMT_S: begin
               src1_reg  = word[19:15];
               src2_reg  = word[24:20];
               immediate = {{20{word[31]}}, word[31:25], word[11:7]};
            end
            rid_pkg::FMT_B: begin
               src1_reg  = word[19:15];
               src2_reg  = word[24:20];
               immediate = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
            end
            rid_pkg::FMT_U: begin
               dest_reg  = word[11:7];
               immediate = {word[31:12], 12'b0};
            end
            rid_pkg::FMT_J: begin
               dest_reg  = word[11:7];
               immediate = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
            end
            default: begin
               dest_reg = '0;
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/riscv_instruction_decoder.sv
// riscv_instruction_decoder: rv32imafd decoder top level, input and result registers
// around rid_match and rid_extract; depends on rid_pkg
// a taken word passes word_ff and the result registers; rsp_valid marks it for one cycle
// throughput: one word every cycle, busy is never raised; the table match is the long path
// reset clears only the valid flags of the two register stages
module riscv_instruction_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rid_pkg::WORD_W-1:0]        req_instruction_word,
   output logic                              rsp_valid,
   output logic [rid_pkg::KIND_W-1:0]        rsp_kind,
   output logic [rid_pkg::REG_W-1:0]         rsp_dest_reg,
   output logic [rid_pkg::REG_W-1:0]         rsp_src1_reg,
   output logic [rid_pkg::REG_W-1:0]         rsp_src2_reg,
   output logic [rid_pkg::REG_W-1:0]         rsp_src3_reg,
   output logic signed [rid_pkg::WORD_W-1:0] rsp_immediate,
   output logic                              rsp_illegal
);

   logic                       in_valid_ff;
   logic [rid_pkg::WORD_W-1:0] word_ff;
   rid_pkg::match_type         match;

   logic [rid_pkg::KIND_W-1:0] kind_in;
   logic [rid_pkg::REG_W-1:0]  dest_in;
   logic [rid_pkg::REG_W-1:0]  src1_in;
   logic [rid_pkg::REG_W-1:0]  src2_in;
   logic [rid_pkg::REG_W-1:0]  src3_in;
   logic [rid_pkg::WORD_W-1:0] imm_in;
   logic                       illegal_in;

   logic                       rsp_valid_ff;
   logic [rid_pkg::KIND_W-1:0] kind_ff;
   logic [rid_pkg::REG_W-1:0]  dest_ff;
   logic [rid_pkg::REG_W-1:0]  src1_ff;
   logic [rid_pkg::REG_W-1:0]  src2_ff;
   logic [rid_pkg::REG_W-1:0]  src3_ff;
   logic [rid_pkg::WORD_W-1:0] imm_ff;
   logic                       illegal_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start && !busy;
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         word_ff <= req_instruction_word;
      end
      if (in_valid_ff) begin
         kind_ff    <= kind_in;
         dest_ff    <= dest_in;
         src1_ff    <= src1_in;
         src2_ff    <= src2_in;
         src3_ff    <= src3_in;
         imm_ff     <= imm_in;
         illegal_ff <= illegal_in;
      end
   end

   rid_match u_match (
      .word  (word_ff),
      .match (match)
   );

   rid_extract u_extract (
      .word      (word_ff),
      .match     (match),
      .kind      (kind_in),
      .dest_reg  (dest_in),
      .src1_reg  (src1_in),
      .src2_reg  (src2_in),
      .src3_reg  (src3_in),
      .immediate (imm_in),
      .illegal   (illegal_in)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_dest_reg  = dest_ff;
   assign rsp_src1_reg  = src1_ff;
   assign rsp_src2_reg  = src2_ff;
   assign rsp_src3_reg  = src3_ff;
   assign rsp_immediate = signed'(imm_ff);
   assign rsp_illegal   = illegal_ff;

`ifndef NO_ASSERTIONS
   a_item_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##2 rsp_valid)
      else $error("accepted item did not produce a result two cycles later");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("result strobe without an accepted item");

   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_illegal) |-> (rsp_kind == '0 && rsp_dest_reg == '0
         && rsp_src1_reg == '0 && rsp_src2_reg == '0 && rsp_src3_reg == '0
         && rsp_immediate == '0))
      else $error("illegal item carries nonzero fields");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_illegal) |-> (rsp_kind < rid_pkg::KIND_W'(rid_pkg::NUM_ENTRIES)))
      else $error("kind out of table range");

   a_upper_imm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_illegal
         && (rsp_kind == rid_pkg::KIND_LUI || rsp_kind == rid_pkg::KIND_AUIPC))
      |-> (rsp_immediate[11:0] == '0 && rsp_src1_reg == '0 && rsp_src2_reg == '0))
      else $error("upper-immediate item decoded with wrong format");
`endif

endmodule

FILE: verif/rid_decode_checker.sv
`timescale 1ns / 100ps
// rid_decode_checker: watches the item and result channels of riscv_instruction_decoder,
// predicts each decode from the word alone and compares every field in order
// depends on rid_pkg for the format enum and the table size
module rid_decode_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [rid_pkg::WORD_W-1:0]        req_instruction_word,
   input  logic                              rsp_valid,
   input  logic [rid_pkg::KIND_W-1:0]        rsp_kind,
   input  logic [rid_pkg::REG_W-1:0]         rsp_dest_reg,
   input  logic [rid_pkg::REG_W-1:0]         rsp_src1_reg,
   input  logic [rid_pkg::REG_W-1:0]         rsp_src2_reg,
   input  logic [rid_pkg::REG_W-1:0]         rsp_src3_reg,
   input  logic signed [rid_pkg::WORD_W-1:0] rsp_immediate,
   input  logic                              rsp_illegal,
   output int                                mismatch_count,
   output int                                pending,
   output int                                results_checked,
   output int                                kinds_covered,
   output int                                illegal_count
);

   localparam logic [6:0] OPC_LOAD     = 7'h03;
   localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
   localparam logic [6:0] OPC_OP_IMM   = 7'h13;
   localparam logic [6:0] OPC_AUIPC    = 7'h17;
   localparam logic [6:0] OPC_STORE    = 7'h23;
   localparam logic [6:0] OPC_STORE_FP = 7'h27;
   localparam logic [6:0] OPC_AMO      = 7'h2f;
   localparam logic [6:0] OPC_OP       = 7'h33;
   localparam logic [6:0] OPC_LUI      = 7'h37;
   localparam logic [6:0] OPC_MADD     = 7'h43;
   localparam logic [6:0] OPC_MSUB     = 7'h47;
   localparam logic [6:0] OPC_NMSUB    = 7'h4b;
   localparam logic [6:0] OPC_NMADD    = 7'h4f;
   localparam logic [6:0] OPC_OP_FP    = 7'h53;
   localparam logic [6:0] OPC_BRANCH   = 7'h63;
   localparam logic [6:0] OPC_JALR     = 7'h67;
   localparam logic [6:0] OPC_JAL      = 7'h6f;
   localparam logic [6:0] OPC_SYSTEM   = 7'h73;

   // numbered densely in table order
   typedef enum logic [rid_pkg::KIND_W-1:0] {
      K_ADD, K_SUB, K_XOR, K_OR, K_AND, K_SLL, K_SRL, K_SRA, K_SLT, K_SLTU,
      K_ADDI, K_XORI, K_ORI, K_ANDI, K_SLLI, K_SRLI, K_SRAI, K_SLTI, K_SLTIU,
      K_LB, K_LH, K_LW, K_LBU, K_LHU,
      K_SB, K_SH, K_SW,
      K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
      K_JAL, K_JALR, K_LUI, K_AUIPC, K_ECALL, K_EBREAK,
      K_MUL, K_MULH, K_MULHSU, K_MULHU, K_DIV, K_DIVU, K_REM, K_REMU,
      K_LR_W, K_SC_W, K_AMOSWAP_W, K_AMOADD_W, K_AMOAND_W, K_AMOOR_W, K_AMOXOR_W,
      K_AMOMAX_W, K_AMOMIN_W, K_AMOMAXU_W, K_AMOMINU_W,
      K_FLW, K_FSW, K_FMADD_S, K_FMSUB_S, K_FNMSUB_S, K_FNMADD_S,
      K_FADD_S, K_FSUB_S, K_FMUL_S, K_FDIV_S, K_FSQRT_S,
      K_FSGNJ_S, K_FSGNJN_S, K_FSGNJX_S, K_FMIN_S, K_FMAX_S,
      K_FCVT_W_S, K_FCVT_WU_S, K_FMV_X_W, K_FEQ_S, K_FLT_S, K_FLE_S, K_FCLASS_S,
      K_FCVT_S_W, K_FCVT_S_WU, K_FMV_W_X,
      K_FLD, K_FSD, K_FMADD_D, K_FMSUB_D, K_FNMSUB_D, K_FNMADD_D,
      K_FADD_D, K_FSUB_D, K_FMUL_D, K_FDIV_D, K_FSQRT_D,
      K_FSGNJ_D, K_FSGNJN_D, K_FSGNJX_D, K_FMIN_D, K_FMAX_D,
      K_FCVT_S_D, K_FCVT_D_S, K_FEQ_D, K_FLT_D, K_FLE_D, K_FCLASS_D,
      K_FCVT_W_D, K_FCVT_WU_D, K_FCVT_D_W, K_FCVT_D_WU
   } instr_kind_type;

   typedef struct packed {
      logic [rid_pkg::WORD_W-1:0] word;
      logic [rid_pkg::KIND_W-1:0] kind;
      logic [rid_pkg::REG_W-1:0]  rd;
      logic [rid_pkg::REG_W-1:0]  rs1;
      logic [rid_pkg::REG_W-1:0]  rs2;
      logic [rid_pkg::REG_W-1:0]  rs3;
      logic [rid_pkg::WORD_W-1:0] imm;
      logic                       illegal;
   } decoded_word_type;

   decoded_word_type                expected_decodes[$];
   logic [rid_pkg::NUM_ENTRIES-1:0] kinds_seen;

   initial begin
      mismatch_count  = 0;
      pending         = 0;
      results_checked = 0;
      kinds_covered   = 0;
      illegal_count   = 0;
      kinds_seen      = '0;
   end

   function automatic void classify(input logic [rid_pkg::WORD_W-1:0] w, output logic hit,
                                    output instr_kind_type k,
                                    output rid_pkg::fmt_type f);
      logic [6:0]  opc;
      logic [6:0]  f7;
      logic [2:0]  f3;
      logic [1:0]  f2;
      logic [4:0]  f5a;
      logic [4:0]  f5f;
      logic [11:0] f12;
      opc = w[6:0];
      f7  = w[31:25];
      f3  = w[14:12];
      f2  = w[26:25];
      f5a = w[31:27];
      f5f = w[24:20];
      f12 = w[31:20];
      hit = 1'b1;
      k   = K_ADD;
      f   = rid_pkg::FMT_R;
      case (opc)
         OPC_OP: begin
            f = rid_pkg::FMT_R;
            if (f7 == 7'h00) begin
               case (f3)
                  3'd0: k = K_ADD;
                  3'd1: k = K_SLL;
                  3'd2: k = K_SLT;
                  3'd3: k = K_SLTU;
                  3'd4: k = K_XOR;
                  3'd5: k = K_SRL;
                  3'd6: k = K_OR;
                  default: k = K_AND;
               endcase
            end else if (f7 == 7'h20 && f3 == 3'd0) begin
               k = K_SUB;
            end else if (f7 == 7'h20 && f3 == 3'd5) begin
               k = K_SRA;
            end else if (f7 == 7'h01) begin
               case (f3)
                  3'd0: k = K_MUL;
                  3'd1: k = K_MULH;
                  3'd2: k = K_MULHSU;
                  3'd3: k = K_MULHU;
                  3'd4: k = K_DIV;
                  3'd5: k = K_DIVU;
                  3'd6: k = K_REM;
                  default: k = K_REMU;
               endcase
            end else begin
               hit = 1'b0;
            end
         end
         OPC_OP_IMM: begin
            f = rid_pkg::FMT_I;
            case (f3)
               3'd0: k = K_ADDI;
               3'd2: k = K_SLTI;
               3'd3: k = K_SLTIU;
               3'd4: k = K_XORI;
               3'd6: k = K_ORI;
               3'd7: k = K_ANDI;
               3'd1: begin
                  k = K_SLLI;
                  hit = (f7 == 7'h00);
               end
               default: begin
                  if (f7 == 7'h00) k = K_SRLI;
                  else if (f7 == 7'h20) k = K_SRAI;
                  else hit = 1'b0;
               end
            endcase
         end
         OPC_LOAD: begin
            f = rid_pkg::FMT_I;
            case (f3)
               3'd0: k = K_LB;
               3'd1: k = K_LH;
               3'd2: k = K_LW;
               3'd4: k = K_LBU;
               3'd5: k = K_LHU;
               default: hit = 1'b0;
            endcase
         end
         OPC_STORE: begin
            f = rid_pkg::FMT_S;
            case (f3)
               3'd0: k = K_SB;
               3'd1: k = K_SH;
               3'd2: k = K_SW;
               default: hit = 1'b0;
            endcase
         end
         OPC_BRANCH: begin
            f = rid_pkg::FMT_B;
            case (f3)
               3'd0: k = K_BEQ;
               3'd1: k = K_BNE;
               3'd4: k = K_BLT;
               3'd5: k = K_BGE;
               3'd6: k = K_BLTU;
               3'd7: k = K_BGEU;
               default: hit = 1'b0;
            endcase
         end
         OPC_JAL: begin
            f = rid_pkg::FMT_J;
            k = K_JAL;
         end
         OPC_JALR: begin
            f = rid_pkg::FMT_I;
            k = K_JALR;
            hit = (f3 == 3'd0);
         end
         OPC_LUI: begin
            f = rid_pkg::FMT_U;
            k = K_LUI;
         end
         OPC_AUIPC: begin
            f = rid_pkg::FMT_U;
            k = K_AUIPC;
         end
         OPC_SYSTEM: begin
            f = rid_pkg::FMT_I;
            if (f3 == 3'd0 && f12 == 12'h000) k = K_ECALL;
            else if (f3 == 3'd0 && f12 == 12'h001) k = K_EBREAK;
            else hit = 1'b0;
         end
         OPC_AMO: begin
            f = rid_pkg::FMT_R;
            if (f3 != 3'd2) begin
               hit = 1'b0;
            end else begin
               case (f5a)
                  5'h00: k = K_AMOADD_W;
                  5'h01: k = K_AMOSWAP_W;
                  5'h02: k = K_LR_W;
                  5'h03: k = K_SC_W;
                  5'h04: k = K_AMOXOR_W;
                  5'h08: k = K_AMOOR_W;
                  5'h0c: k = K_AMOAND_W;
                  5'h10: k = K_AMOMIN_W;
                  5'h14: k = K_AMOMAX_W;
                  5'h18: k = K_AMOMINU_W;
                  5'h1c: k = K_AMOMAXU_W;
                  default: hit = 1'b0;
               endcase
            end
         end
         OPC_LOAD_FP: begin
            f = rid_pkg::FMT_I;
            if (f3 == 3'd2) k = K_FLW;
            else if (f3 == 3'd3) k = K_FLD;
            else hit = 1'b0;
         end
         OPC_STORE_FP: begin
            f = rid_pkg::FMT_S;
            if (f3 == 3'd2) k = K_FSW;
            else if (f3 == 3'd3) k = K_FSD;
            else hit = 1'b0;
         end
         OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: begin
            f = rid_pkg::FMT_R4;
            hit = !f2[1];
            case (opc)
               OPC_MADD: begin
                  if (f2[0]) k = K_FMADD_D;
                  else k = K_FMADD_S;
               end
               OPC_MSUB: begin
                  if (f2[0]) k = K_FMSUB_D;
                  else k = K_FMSUB_S;
               end
               OPC_NMSUB: begin
                  if (f2[0]) k = K_FNMSUB_D;
                  else k = K_FNMSUB_S;
               end
               default: begin
                  if (f2[0]) k = K_FNMADD_D;
                  else k = K_FNMADD_S;
               end
            endcase
         end
         OPC_OP_FP: begin
            f = rid_pkg::FMT_R;
            case (f7)
               7'h00: k = K_FADD_S;
               7'h04: k = K_FSUB_S;
               7'h08: k = K_FMUL_S;
               7'h0c: k = K_FDIV_S;
               7'h01: k = K_FADD_D;
               7'h05: k = K_FSUB_D;
               7'h09: k = K_FMUL_D;
               7'h0d: k = K_FDIV_D;
               7'h2c: begin
                  k = K_FSQRT_S;
                  hit = (f5f == 5'd0);
               end
               7'h2d: begin
                  k = K_FSQRT_D;
                  hit = (f5f == 5'd0);
               end
               7'h10: begin
                  if (f3 == 3'd0) k = K_FSGNJ_S;
                  else if (f3 == 3'd1) k = K_FSGNJN_S;
                  else if (f3 == 3'd2) k = K_FSGNJX_S;
                  else hit = 1'b0;
               end
               7'h11: begin
                  if (f3 == 3'd0) k = K_FSGNJ_D;
                  else if (f3 == 3'd1) k = K_FSGNJN_D;
                  else if (f3 == 3'd2) k = K_FSGNJX_D;
                  else hit = 1'b0;
               end
               7'h14: begin
                  if (f3 == 3'd0) k = K_FMIN_S;
                  else if (f3 == 3'd1) k = K_FMAX_S;
                  else hit = 1'b0;
               end
               7'h15: begin
                  if (f3 == 3'd0) k = K_FMIN_D;
                  else if (f3 == 3'd1) k = K_FMAX_D;
                  else hit = 1'b0;
               end
               7'h60: begin
                  if (f5f == 5'd0) k = K_FCVT_W_S;
                  else if (f5f == 5'd1) k = K_FCVT_WU_S;
                  else hit = 1'b0;
               end
               7'h61: begin
                  if (f5f == 5'd0) k = K_FCVT_W_D;
                  else if (f5f == 5'd1) k = K_FCVT_WU_D;
                  else hit = 1'b0;
               end
               7'h70: begin
                  if (f5f == 5'd0 && f3 == 3'd0) k = K_FMV_X_W;
                  else if (f5f == 5'd0 && f3 == 3'd1) k = K_FCLASS_S;
                  else hit = 1'b0;
               end
               7'h71: begin
                  k = K_FCLASS_D;
                  hit = (f5f == 5'd0 && f3 == 3'd1);
               end
               7'h50: begin
                  if (f3 == 3'd2) k = K_FEQ_S;
                  else if (f3 == 3'd1) k = K_FLT_S;
                  else if (f3 == 3'd0) k = K_FLE_S;
                  else hit = 1'b0;
               end
               7'h51: begin
                  if (f3 == 3'd2) k = K_FEQ_D;
                  else if (f3 == 3'd1) k = K_FLT_D;
                  else if (f3 == 3'd0) k = K_FLE_D;
                  else hit = 1'b0;
               end
               7'h68: begin
                  if (f5f == 5'd0) k = K_FCVT_S_W;
                  else if (f5f == 5'd1) k = K_FCVT_S_WU;
                  else hit = 1'b0;
               end
               7'h69: begin
                  if (f5f == 5'd0) k = K_FCVT_D_W;
                  else if (f5f == 5'd1 && f3 == 3'd0) k = K_FCVT_D_WU;
                  else hit = 1'b0;
               end
               7'h78: begin
                  k = K_FMV_W_X;
                  hit = (f5f == 5'd0 && f3 == 3'd0);
               end
               7'h20: begin
                  k = K_FCVT_S_D;
                  hit = (f5f == 5'd1);
               end
               7'h21: begin
                  k = K_FCVT_D_S;
                  hit = (f5f == 5'd0);
               end
               default: hit = 1'b0;
            endcase
         end
         default: hit = 1'b0;
      endcase
   endfunction

   function automatic decoded_word_type predict_decode(input logic [rid_pkg::WORD_W-1:0] w);
      decoded_word_type d;
      logic             hit;
      instr_kind_type   k;
      rid_pkg::fmt_type f;
      classify(w, hit, k, f);
      d = '0;
      d.word = w;
      if (!hit) begin
         d.illegal = 1'b1;
         return d;
      end
      d.kind = k;
      case (f)
         rid_pkg::FMT_R4: begin
            d.rd  = w[11:7];
            d.rs1 = w[19:15];
            d.rs2 = w[24:20];
            d.rs3 = w[31:27];
         end
         rid_pkg::FMT_R: begin
            d.rd  = w[11:7];
            d.rs1 = w[19:15];
            d.rs2 = w[24:20];
         end
         rid_pkg::FMT_I: begin
            d.rd  = w[11:7];
            d.rs1 = w[19:15];
            d.imm = {{20{w[31]}}, w[31:20]};
         end
         rid_pkg::FMT_S: begin
            d.rs1 = w[19:15];
            d.rs2 = w[24:20];
            d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
         end
         rid_pkg::FMT_B: begin
            d.rs1 = w[19:15];
            d.rs2 = w[24:20];
            d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         end
         rid_pkg::FMT_U: begin
            d.rd  = w[11:7];
            d.imm = {w[31:12], 12'h000};
         end
         default: begin
            d.rd  = w[11:7];
            d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         end
      endcase
      return d;
   endfunction

   task automatic report_mismatch(input string field,
                                  input logic [rid_pkg::WORD_W-1:0] word,
                                  input logic [rid_pkg::WORD_W-1:0] got,
                                  input logic [rid_pkg::WORD_W-1:0] want);
      $display("%0t: %s mismatch for word %h: got %h, expected %h",
               $time, field, word, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      decoded_word_type want;
      if (!reset) begin
         if (start && !busy) expected_decodes.push_back(predict_decode(req_instruction_word));
         if (rsp_valid) begin
            if (expected_decodes.size() == 0) begin
               report_mismatch("unexpected result", '0, rid_pkg::WORD_W'(rsp_kind), '0);
            end else begin
               want = expected_decodes.pop_front();
               if (rsp_illegal !== want.illegal)
                  report_mismatch("illegal", want.word, rid_pkg::WORD_W'(rsp_illegal),
                                  rid_pkg::WORD_W'(want.illegal));
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", want.word, rid_pkg::WORD_W'(rsp_kind),
                                  rid_pkg::WORD_W'(want.kind));
               if (rsp_dest_reg !== want.rd)
                  report_mismatch("dest_reg", want.word, rid_pkg::WORD_W'(rsp_dest_reg),
                                  rid_pkg::WORD_W'(want.rd));
               if (rsp_src1_reg !== want.rs1)
                  report_mismatch("src1_reg", want.word, rid_pkg::WORD_W'(rsp_src1_reg),
                                  rid_pkg::WORD_W'(want.rs1));
               if (rsp_src2_reg !== want.rs2)
                  report_mismatch("src2_reg", want.word, rid_pkg::WORD_W'(rsp_src2_reg),
                                  rid_pkg::WORD_W'(want.rs2));
               if (rsp_src3_reg !== want.rs3)
                  report_mismatch("src3_reg", want.word, rid_pkg::WORD_W'(rsp_src3_reg),
                                  rid_pkg::WORD_W'(want.rs3));
               if (rsp_immediate !== want.imm)
                  report_mismatch("immediate", want.word, rsp_immediate, want.imm);
               if (want.illegal) illegal_count++;
               else kinds_seen[want.kind] = 1'b1;
               results_checked++;
               kinds_covered = $countones(kinds_seen);
            end
         end
      end
      pending = expected_decodes.size();
   end

endmodule

FILE: verif/tb_riscv_instruction_decoder.sv
`timescale 1ns / 100ps
// tb_riscv_instruction_decoder: drives instruction words into riscv_instruction_decoder
// under three idle settings and gives the verdict; depends on rid_pkg and rid_decode_checker
module tb_riscv_instruction_decoder;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [rid_pkg::WORD_W-1:0]        req_instruction_word;
   logic                              rsp_valid;
   logic [rid_pkg::KIND_W-1:0]        rsp_kind;
   logic [rid_pkg::REG_W-1:0]         rsp_dest_reg;
   logic [rid_pkg::REG_W-1:0]         rsp_src1_reg;
   logic [rid_pkg::REG_W-1:0]         rsp_src2_reg;
   logic [rid_pkg::REG_W-1:0]         rsp_src3_reg;
   logic signed [rid_pkg::WORD_W-1:0] rsp_immediate;
   logic                              rsp_illegal;

   int mismatch_count;
   int pending;
   int results_checked;
   int kinds_covered;
   int illegal_count;
   int idle_pct;
   int words_sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   riscv_instruction_decoder dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_instruction_word (req_instruction_word),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_dest_reg         (rsp_dest_reg),
      .rsp_src1_reg         (rsp_src1_reg),
      .rsp_src2_reg         (rsp_src2_reg),
      .rsp_src3_reg         (rsp_src3_reg),
      .rsp_immediate        (rsp_immediate),
      .rsp_illegal          (rsp_illegal)
   );

   rid_decode_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_instruction_word (req_instruction_word),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_dest_reg         (rsp_dest_reg),
      .rsp_src1_reg         (rsp_src1_reg),
      .rsp_src2_reg         (rsp_src2_reg),
      .rsp_src3_reg         (rsp_src3_reg),
      .rsp_immediate        (rsp_immediate),
      .rsp_illegal          (rsp_illegal),
      .mismatch_count       (mismatch_count),
      .pending              (pending),
      .results_checked      (results_checked),
      .kinds_covered        (kinds_covered),
      .illegal_count        (illegal_count)
   );

   // overlay the fixed fields of one table entry on a fill word
   function automatic logic [rid_pkg::WORD_W-1:0] encode_kind(
      input int k, input logic [rid_pkg::WORD_W-1:0] fill);
      rid_pkg::pattern_type       p;
      logic [rid_pkg::WORD_W-1:0] w;
      p = rid_pkg::PATTERNS[k];
      w = fill;
      w[6:0] = p.opc;
      if (p.f7_care) w[31:25] = p.f7;
      if (p.f2_care) w[26:25] = p.f2;
      if (p.f5a_care) w[31:27] = p.f5a;
      if (p.f12_care) w[31:20] = p.f12;
      if (p.f5f_care) w[24:20] = p.f5f;
      if (p.f3_care) w[14:12] = p.f3;
      return w;
   endfunction

   // mostly valid encodings with random operands, then near misses and raw noise
   function automatic logic [rid_pkg::WORD_W-1:0] random_word();
      int unsigned                roll;
      logic [4:0]                 idx;
      logic [rid_pkg::WORD_W-1:0] w;
      roll = $urandom_range(99);
      w = encode_kind($urandom_range(rid_pkg::NUM_ENTRIES - 1), $urandom);
      if (roll >= 85) begin
         w = $urandom;
      end else if (roll >= 70) begin
         idx = 5'($urandom_range(rid_pkg::WORD_W - 1));
         w[idx] = ~w[idx];
      end
      return w;
   endfunction

   task automatic issue(input logic [rid_pkg::WORD_W-1:0] w);
      int   gap;
      logic stalled;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_instruction_word <= w;
      do begin
         @(negedge clock);
         stalled = busy;
         @(posedge clock);
      end while (stalled);
      words_sent++;
   endtask

   task automatic wait_drained();
      int cycles;
      cycles = 0;
      start <= 1'b0;
      do begin
         @(negedge clock);
         cycles++;
      end while (pending != 0 && cycles < 1000);
      @(posedge clock);
   endtask

   initial begin
      logic [(1 << $bits(rid_pkg::fmt_type))-1:0] fmt_done;
      reset <= 1'b1;
      start <= 1'b0;
      req_instruction_word <= '0;
      idle_pct = 32;
      words_sent = 0;
      fmt_done = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // all-zero and all-one words, each format at both operand extremes
      issue('0);
      issue('1);
      for (int k = 0; k < rid_pkg::NUM_ENTRIES; k++) begin
         if (!fmt_done[rid_pkg::PATTERNS[k].fmt]) begin
            fmt_done[rid_pkg::PATTERNS[k].fmt] = 1'b1;
            issue(encode_kind(k, '0));
            issue(encode_kind(k, '1));
         end
         // shifts: all-one shift amount; bit 30 flip swaps SRLI/SRAI, makes SLLI illegal
         if (rid_pkg::PATTERNS[k].fmt == rid_pkg::FMT_I && rid_pkg::PATTERNS[k].f7_care) begin
            issue(encode_kind(k, '1));
            issue(encode_kind(k, '0) ^ 32'h4000_0000);
         end
      end
      issue(encode_kind(int'(rid_pkg::KIND_LUI), 32'hA5A5_A5A5));
      issue(encode_kind(int'(rid_pkg::KIND_AUIPC), 32'h5A5A_5A5A));

      for (int k = 0; k < rid_pkg::NUM_ENTRIES; k++) issue(encode_kind(k, $urandom));
      repeat (120) issue(random_word());
      wait_drained();

      idle_pct = 70;
      repeat (230) issue(random_word());
      wait_drained();

      idle_pct = 0;
      repeat (240) issue(random_word());
      wait_drained();
      repeat (4) @(negedge clock);

      $display("sent %0d words over three idle settings; %0d decodes checked",
               words_sent, results_checked);
      $display("%0d of %0d kinds decoded, %0d words flagged illegal",
               kinds_covered, rid_pkg::NUM_ENTRIES, illegal_count);
      if (mismatch_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
